### src/assert_macros.svh
// Assertion helpers for the calendar block; they expand to nothing for synthesis.
// Each use names the label, the antecedent, the consequent and the message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GDOD_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define GDOD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define GDOD_ASSERT_IMPL(label, ante, cons, msg)
`define GDOD_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### src/gdod_pkg.sv
package gdod_pkg;

	// day counts from 1 January of year 0 stay below 2^23 for any supported span
	localparam int unsigned DAYS_W = 24;
	// year counter reaches base year plus span
	localparam int unsigned YCNT_W = 14;

	// floor(x / 100) for x below 2^13: (x * 5243) >> 19
	localparam logic [12:0]  DIV100_MUL   = 13'd5243;
	localparam int unsigned  DIV100_SHIFT = 19;
	// floor(x / 7) for x below 2^24: (x * 19173962) >> 27
	localparam logic [24:0]  MOD7_MUL     = 25'd19173962;
	localparam int unsigned  MOD7_SHIFT   = 27;

	typedef enum logic {
		OP_ADD  = 1'b0,
		OP_DIFF = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_CLAMP,
		ST_ABS,
		ST_SPLIT,
		ST_YEAR,
		ST_MONTH,
		ST_WQ,
		ST_WR,
		ST_DONE
	} state_t;

	// one request as taken from the input side
	typedef struct packed {
		op_t         opcode;
		logic [4:0]  day_of_month;
		logic [3:0]  month;
		logic [11:0] year;
		logic [18:0] day_offset;
		logic [4:0]  other_day;
		logic [3:0]  other_month;
		logic [11:0] other_year;
	} req_t;

	// one result as handed to the output register
	typedef struct packed {
		logic [4:0]  out_day;
		logic [3:0]  out_month;
		logic [11:0] out_year;
		logic [2:0]  weekday;
		logic [8:0]  yday;
		logic [18:0] day_difference;
		logic        out_of_range;
	} res_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic prep;
		logic clamp;
		logic absd;
		logic split;
		logic year_step;
		logic month_step;
		logic wd_mul;
		logic wd_rem;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		op_t  op;
		logic split_oor;
		logic year_done;
		logic month_done;
	} sts_t;

	function automatic logic [6:0] div100(input logic [12:0] x);
		logic [25:0] p;
		p = 26'(x) * 26'(DIV100_MUL);
		return 7'(p >> DIV100_SHIFT);
	endfunction

	// month length, month in 1..12
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] l;
		case (m)
			4'd2: begin
				l = leap ? 5'd29 : 5'd28;
			end
			4'd4, 4'd6, 4'd9, 4'd11: begin
				l = 5'd30;
			end
			default: begin
				l = 5'd31;
			end
		endcase
		return l;
	endfunction

	// days in the year before the first of month m
	function automatic logic [8:0] days_before_month(input logic [3:0] m, input logic leap);
		logic [8:0] s;
		case (m)
			4'd1:    s = 9'd0;
			4'd2:    s = 9'd31;
			4'd3:    s = 9'd59;
			4'd4:    s = 9'd90;
			4'd5:    s = 9'd120;
			4'd6:    s = 9'd151;
			4'd7:    s = 9'd181;
			4'd8:    s = 9'd212;
			4'd9:    s = 9'd243;
			4'd10:   s = 9'd273;
			4'd11:   s = 9'd304;
			4'd12:   s = 9'd334;
			default: s = 9'd0;
		endcase
		if (leap && (m > 4'd2)) begin
			s = s + 9'd1;
		end
		return s;
	endfunction

endpackage

### src/gdod_ctrl.sv
module gdod_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              out_free,
	input  gdod_pkg::sts_t    sts,
	output gdod_pkg::cmd_t    cmd
);

	gdod_pkg::state_t state_q;
	gdod_pkg::state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gdod_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			gdod_pkg::ST_IDLE: begin
				if (in_valid) state_d = gdod_pkg::ST_PREP;
			end
			gdod_pkg::ST_PREP:  state_d = gdod_pkg::ST_CLAMP;
			gdod_pkg::ST_CLAMP: state_d = gdod_pkg::ST_ABS;
			gdod_pkg::ST_ABS:   state_d = gdod_pkg::ST_SPLIT;
			gdod_pkg::ST_SPLIT: begin
				if (sts.op == gdod_pkg::OP_DIFF) begin
					state_d = gdod_pkg::ST_WQ;
				end else if (sts.split_oor) begin
					state_d = gdod_pkg::ST_DONE;
				end else begin
					state_d = gdod_pkg::ST_YEAR;
				end
			end
			gdod_pkg::ST_YEAR: begin
				if (sts.year_done) state_d = gdod_pkg::ST_MONTH;
			end
			gdod_pkg::ST_MONTH: begin
				if (sts.month_done) state_d = gdod_pkg::ST_WQ;
			end
			gdod_pkg::ST_WQ: state_d = gdod_pkg::ST_WR;
			gdod_pkg::ST_WR: state_d = gdod_pkg::ST_DONE;
			gdod_pkg::ST_DONE: begin
				if (out_free) state_d = gdod_pkg::ST_IDLE;
			end
			default: state_d = gdod_pkg::ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			gdod_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			gdod_pkg::ST_PREP:  cmd.prep       = 1'b1;
			gdod_pkg::ST_CLAMP: cmd.clamp      = 1'b1;
			gdod_pkg::ST_ABS:   cmd.absd       = 1'b1;
			gdod_pkg::ST_SPLIT: cmd.split      = 1'b1;
			gdod_pkg::ST_YEAR:  cmd.year_step  = 1'b1;
			gdod_pkg::ST_MONTH: cmd.month_step = 1'b1;
			gdod_pkg::ST_WQ:    cmd.wd_mul     = 1'b1;
			gdod_pkg::ST_WR:    cmd.wd_rem     = 1'b1;
			gdod_pkg::ST_DONE:  cmd.emit       = out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

### src/gdod_dp.sv
`include "assert_macros.svh"

module gdod_dp #(
	parameter int unsigned BASE_YEAR = 1900,
	parameter int unsigned YEAR_SPAN = 512
) (
	input  logic              clk,
	input  logic              arst_n,
	input  gdod_pkg::req_t    req,
	input  gdod_pkg::cmd_t    cmd,
	output gdod_pkg::sts_t    sts,
	output gdod_pkg::res_t    res
);

	localparam int unsigned DW         = gdod_pkg::DAYS_W;
	localparam int unsigned YW         = gdod_pkg::YCNT_W;
	localparam int unsigned END_YEAR   = BASE_YEAR + YEAR_SPAN;
	localparam int unsigned BASE_DAYS  = 365 * BASE_YEAR + (BASE_YEAR + 3) / 4
		- (BASE_YEAR + 99) / 100 + (BASE_YEAR + 399) / 400;
	localparam int unsigned END_DAYS   = 365 * END_YEAR + (END_YEAR + 3) / 4
		- (END_YEAR + 99) / 100 + (END_YEAR + 399) / 400;
	localparam int unsigned SPAN_DAYS  = END_DAYS - BASE_DAYS;
	localparam int unsigned BASE_MOD4  = BASE_YEAR % 4;
	localparam int unsigned BASE_MOD100 = BASE_YEAR % 100;
	localparam int unsigned BASE_MOD400 = BASE_YEAR % 400;

	// clamp month and day; returns {month, day, day of year}
	function automatic logic [17:0] clamp_date(input logic [4:0] d, input logic [3:0] m,
		input logic [11:0] y, input logic [6:0] qa);
		logic [11:0] h;
		logic        leap;
		logic [3:0]  mc;
		logic [4:0]  ml;
		logic [4:0]  dc;
		logic [8:0]  od;
		h    = 12'({5'd0, qa} * 12'd100);
		leap = (y[1:0] == 2'd0) && ((y != h) || (qa[1:0] == 2'd0));
		if (m == 4'd0) begin
			mc = 4'd1;
		end else if (m > 4'd12) begin
			mc = 4'd12;
		end else begin
			mc = m;
		end
		ml = gdod_pkg::month_len(mc, leap);
		if (d == 5'd0) begin
			dc = 5'd1;
		end else if (d > ml) begin
			dc = ml;
		end else begin
			dc = d;
		end
		od = gdod_pkg::days_before_month(mc, leap) + 9'(dc);
		return {mc, dc, od};
	endfunction

	// days from 1 January of year 0 to the given date
	function automatic logic [DW-1:0] abs_days(input logic [11:0] y, input logic [6:0] qb,
		input logic [6:0] qc, input logic [8:0] od);
		logic [DW-1:0] s;
		s = DW'(y) * DW'(365) + DW'((13'(y) + 13'd3) >> 2) - DW'(qb) + DW'(qc >> 2);
		return s + DW'(od) - DW'(1);
	endfunction

	gdod_pkg::req_t req_q;
	logic [6:0]     qa1_q, qb1_q, qc1_q, qa2_q, qb2_q, qc2_q;
	logic [3:0]     mc1_q;
	logic [4:0]     dc1_q;
	logic [8:0]     od1_q, od2_q;
	logic [DW-1:0]  abs1_q, abs2_q;
	logic [DW-1:0]  cnt_q;
	logic [DW-1:0]  wx_q;
	logic [DW-1:0]  q7_q;
	logic [YW-1:0]  yr_q;
	logic [1:0]     r4_q;
	logic [6:0]     r100_q;
	logic [8:0]     r400_q;
	logic [3:0]     rm_q;
	logic [4:0]     rd_q;
	logic [8:0]     doy_q;
	logic [2:0]     wd_q;
	logic [18:0]    diff_q;
	logic           oor_q;

	logic [17:0]        cl1, cl2;
	logic signed [25:0] off_s, n_s, v_s;
	logic               add_oor;
	logic               v_hi, v_lo;
	logic [18:0]        v_sat;
	logic               yin1, yin2;
	logic               leap_c;
	logic [8:0]         ylen;
	logic [4:0]         mlen;
	logic [48:0]        prod7;
	logic [DW-1:0]      q7x7;

	assign cl1 = clamp_date(req_q.day_of_month, req_q.month, req_q.year, qa1_q);
	assign cl2 = clamp_date(req_q.other_day, req_q.other_month, req_q.other_year, qa2_q);

	// offset path: day count relative to the base year
	assign off_s   = {{7{req_q.day_offset[18]}}, req_q.day_offset};
	assign n_s     = $signed({2'b00, abs1_q}) + off_s - $signed(26'(BASE_DAYS));
	assign add_oor = n_s[25] || (n_s[24:0] >= 25'(SPAN_DAYS));

	// difference path with saturation to 19 bits
	assign v_s   = $signed({2'b00, abs1_q}) - $signed({2'b00, abs2_q});
	assign v_hi  = v_s > $signed(26'sd262143);
	assign v_lo  = v_s < -$signed(26'sd262144);
	assign v_sat = v_hi ? 19'h3FFFF : (v_lo ? 19'h40000 : v_s[18:0]);
	assign yin1  = ({2'b00, req_q.year} >= YW'(BASE_YEAR))
		&& ({2'b00, req_q.year} < YW'(END_YEAR));
	assign yin2  = ({2'b00, req_q.other_year} >= YW'(BASE_YEAR))
		&& ({2'b00, req_q.other_year} < YW'(END_YEAR));

	// year and month stepping
	assign leap_c = (r4_q == 2'd0) && ((r100_q != 7'd0) || (r400_q == 9'd0));
	assign ylen   = leap_c ? 9'd366 : 9'd365;
	assign mlen   = gdod_pkg::month_len(rm_q, leap_c);

	// weekday by reciprocal of seven
	assign prod7 = 49'(wx_q) * 49'(gdod_pkg::MOD7_MUL);
	assign q7x7  = DW'(q7_q * DW'(7));

	assign sts.op         = req_q.opcode;
	assign sts.split_oor  = add_oor;
	assign sts.year_done  = cnt_q < DW'(ylen);
	assign sts.month_done = (rm_q == 4'd12) || (cnt_q < DW'(mlen));

	assign res.out_day        = rd_q;
	assign res.out_month      = rm_q;
	assign res.out_year       = yr_q[11:0];
	assign res.weekday        = wd_q;
	assign res.yday           = doy_q;
	assign res.day_difference = diff_q;
	assign res.out_of_range   = oor_q;

	// request capture, year quotients, clamped dates and absolute day counts
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
		if (cmd.prep) begin
			qa1_q <= gdod_pkg::div100({1'b0, req_q.year});
			qb1_q <= gdod_pkg::div100(13'({1'b0, req_q.year}) + 13'd99);
			qc1_q <= gdod_pkg::div100(13'({1'b0, req_q.year}) + 13'd399);
			qa2_q <= gdod_pkg::div100({1'b0, req_q.other_year});
			qb2_q <= gdod_pkg::div100(13'({1'b0, req_q.other_year}) + 13'd99);
			qc2_q <= gdod_pkg::div100(13'({1'b0, req_q.other_year}) + 13'd399);
		end
		if (cmd.clamp) begin
			{mc1_q, dc1_q, od1_q} <= cl1;
			// only the ordinal of the second date is needed
			od2_q <= cl2[8:0];
		end
		if (cmd.absd) begin
			abs1_q <= abs_days(req_q.year, qb1_q, qc1_q, od1_q);
			abs2_q <= abs_days(req_q.other_year, qb2_q, qc2_q, od2_q);
		end
	end

	// result registers and stepping counters
	always_ff @(posedge clk) begin
		if (cmd.split) begin
			wd_q   <= 3'd0;
			r4_q   <= 2'(BASE_MOD4);
			r100_q <= 7'(BASE_MOD100);
			r400_q <= 9'(BASE_MOD400);
			cnt_q  <= n_s[DW-1:0];
			if (req_q.opcode == gdod_pkg::OP_DIFF) begin
				rd_q   <= dc1_q;
				rm_q   <= mc1_q;
				yr_q   <= {2'b00, req_q.year};
				doy_q  <= od1_q;
				diff_q <= v_sat;
				oor_q  <= !yin1 || !yin2 || v_hi || v_lo;
				wx_q   <= abs1_q + DW'(6);
			end else begin
				rd_q   <= 5'd0;
				rm_q   <= 4'd0;
				yr_q   <= add_oor ? YW'(0) : YW'(BASE_YEAR);
				doy_q  <= 9'd0;
				diff_q <= 19'd0;
				oor_q  <= add_oor;
				wx_q   <= n_s[DW-1:0] + DW'(BASE_DAYS) + DW'(6);
			end
		end
		if (cmd.year_step) begin
			if (!sts.year_done) begin
				cnt_q  <= cnt_q - DW'(ylen);
				yr_q   <= yr_q + YW'(1);
				r4_q   <= r4_q + 2'd1;
				r100_q <= (r100_q == 7'd99) ? 7'd0 : r100_q + 7'd1;
				r400_q <= (r400_q == 9'd399) ? 9'd0 : r400_q + 9'd1;
			end else begin
				doy_q <= 9'(cnt_q) + 9'd1;
				rm_q  <= 4'd1;
			end
		end
		if (cmd.month_step) begin
			if (!sts.month_done) begin
				cnt_q <= cnt_q - DW'(mlen);
				rm_q  <= rm_q + 4'd1;
			end else begin
				rd_q <= 5'(cnt_q) + 5'd1;
			end
		end
		if (cmd.wd_mul) begin
			q7_q <= DW'(prod7 >> gdod_pkg::MOD7_SHIFT);
		end
		if (cmd.wd_rem) begin
			wd_q <= 3'(wx_q - q7x7);
		end
	end

	`GDOD_ASSERT_IMPL(a_month_span, cmd.month_step, (rm_q >= 4'd1) && (rm_q <= 4'd12), "month counter outside 1 to 12")
	`GDOD_ASSERT_IMPL(a_year_bound, cmd.year_step, yr_q < YW'(END_YEAR), "year counter ran past the span")
	`GDOD_ASSERT_NEXT(a_weekday_rng, cmd.wd_rem, wd_q <= 3'd6, "weekday remainder above six")

endmodule

### src/gregorian_date_offset_and_difference.sv
// Gregorian date arithmetic on a stream: tuser 0 adds a signed day offset to a date and
// returns the new date with its weekday (Sunday 0) and day of year; tuser 1 returns the
// first date minus the second in days, saturated to 19 bits, and echoes the first date.
// Months and days out of range are clamped; out_of_range flags a result outside
// BASE_YEAR .. BASE_YEAR+YEAR_SPAN-1; for a difference also either year outside it or a
// saturated count. One request is in flight at a time. Each passes the prep, clamp,
// absolute-day and split states; a difference goes to the weekday states, an offset
// that lands outside the span goes straight to done, and any other offset steps one
// year at a time from BASE_YEAR to the result year and one month at a time to the
// result month. A result not yet taken holds the block in done. The result sits in
// an output register, so the next request is taken while it waits for its transfer.
`include "assert_macros.svh"

module gregorian_date_offset_and_difference #(
	parameter int unsigned BASE_YEAR = 1900,
	parameter int unsigned YEAR_SPAN = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// day_of_month, month, year, day_offset, other_day, other_month, other_year
	input  logic [63:0] s_axis_tdata,
	// opcode
	input  logic [0:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// out_day, out_month, out_year, weekday, yday, day_difference
	output logic [55:0] m_axis_tdata,
	// out_of_range
	output logic [0:0]  m_axis_tuser
);

	gdod_pkg::req_t req;
	gdod_pkg::res_t res;
	gdod_pkg::cmd_t cmd;
	gdod_pkg::sts_t sts;
	logic           out_free;
	logic           m_tvalid_q;
	logic [55:0]    m_tdata_q;
	logic [0:0]     m_tuser_q;

	// unpack the request
	assign req.opcode       = gdod_pkg::op_t'(s_axis_tuser[0]);
	assign req.day_of_month = s_axis_tdata[4:0];
	assign req.month        = s_axis_tdata[8:5];
	assign req.year         = s_axis_tdata[20:9];
	assign req.day_offset   = s_axis_tdata[39:21];
	assign req.other_day    = s_axis_tdata[44:40];
	assign req.other_month  = s_axis_tdata[48:45];
	assign req.other_year   = s_axis_tdata[60:49];

	gdod_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.out_free (out_free),
		.sts      (sts),
		.cmd      (cmd)
	);

	gdod_dp #(
		.BASE_YEAR (BASE_YEAR),
		.YEAR_SPAN (YEAR_SPAN)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.res    (res)
	);

	// output register, free once its transfer completes
	assign out_free = !m_tvalid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			m_tdata_q <= {4'd0, res.day_difference, res.yday, res.weekday,
				res.out_year, res.out_month, res.out_day};
			m_tuser_q <= res.out_of_range;
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tuser  = m_tuser_q;

	`GDOD_ASSERT_IMPL(a_emit_free, cmd.emit, !m_tvalid_q || m_axis_tready, "result loaded over one not yet taken")

endmodule
